// ===== hw/rtl/atm_pkg.sv =====
package atm_pkg;

    localparam logic       ACTION_ACK   = 1'b1;
    localparam logic [1:0] REGION_VALID = 2'd1;
    localparam logic [1:0] REGION_BEGIN = 2'd2;

    localparam int          CMD_DEPTH   = 2;
    localparam int          CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int          CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    localparam int          DVD_W       = 35;
    localparam int          DIV_CNT_W   = $clog2(DVD_W + 1);
    localparam logic [30:0] RATE_MAX    = 31'h7FFF_FFFF;
    localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic        conn_ack_valid;
        logic        history_ack_valid;
        logic        conn_established;
        logic [1:0]  region_code;
        logic [31:0] peer_timestamp;
        logic [29:0] acked_bytes;
    } in_item_t;

    typedef struct packed {
        logic        measure_valid;
        logic [31:0] period_ms;
        logic [31:0] byte_total;
        logic [30:0] rate_kbps;
    } result_t;

    typedef struct packed {
        logic        is_ack;
        logic        qualified;
        logic        begin_region;
        logic [31:0] stamp;
        logic [29:0] acked;
    } cmd_t;

endpackage

// ===== hw/rtl/atm_front.sv =====
module atm_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  atm_pkg::in_item_t item,
    output logic             cmd_valid,
    input  logic             cmd_take,
    output atm_pkg::cmd_t    cmd
);

    atm_pkg::cmd_t                  slot_reg [atm_pkg::CMD_DEPTH];
    logic [atm_pkg::CMD_PTR_W-1:0]  wr_ptr_reg;
    logic [atm_pkg::CMD_PTR_W-1:0]  rd_ptr_reg;
    logic [atm_pkg::CMD_CNT_W-1:0]  count_reg;
    logic [atm_pkg::CMD_CNT_W-1:0]  count_next;
    atm_pkg::cmd_t                  classified;
    logic                           wr_en;
    logic                           rd_en;

    // classify the incoming event
    always_comb
    begin
        classified.is_ack       = (item.action == atm_pkg::ACTION_ACK);
        classified.qualified    = item.conn_ack_valid && item.history_ack_valid &&
                                  item.conn_established &&
                                  ((item.region_code == atm_pkg::REGION_VALID) ||
                                   (item.region_code == atm_pkg::REGION_BEGIN));
        classified.begin_region = (item.region_code == atm_pkg::REGION_BEGIN);
        classified.stamp        = item.peer_timestamp;
        classified.acked        = item.acked_bytes;
    end

    assign full      = (count_reg == atm_pkg::CMD_CNT_W'(atm_pkg::CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== hw/rtl/atm_div.sv =====
module atm_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [atm_pkg::DVD_W-1:0]   dividend,
    input  logic [31:0]                 divisor,
    output logic                        done,
    output logic [atm_pkg::DVD_W-1:0]   quotient
);

    logic [31:0]                    rem_reg;
    logic [atm_pkg::DVD_W-1:0]      dvd_reg;
    logic [atm_pkg::DVD_W-1:0]      quo_reg;
    logic [31:0]                    dsr_reg;
    logic [atm_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [32:0]                    shifted;
    logic [32:0]                    diff;
    logic                           fits;

    assign shifted = {rem_reg, dvd_reg[atm_pkg::DVD_W-1]};
    assign fits    = (shifted >= {1'b0, dsr_reg});
    assign diff    = shifted - {1'b0, dsr_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= atm_pkg::DIV_CNT_W'(atm_pkg::DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == atm_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            quo_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[31:0] : shifted[31:0];
            dvd_reg <= {dvd_reg[atm_pkg::DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[atm_pkg::DVD_W-2:0], fits};
        end
    end

endmodule

// ===== hw/rtl/atm_back.sv =====
module atm_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  atm_pkg::cmd_t     cmd,
    output logic              empty,
    input  logic              pop,
    output atm_pkg::result_t  result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [31:0]       prev_stamp_reg;
    logic [31:0]       prev_stamp_next;
    logic [31:0]       held_bytes_reg;
    logic [31:0]       held_bytes_next;
    logic [31:0]       kept_period_reg;
    logic [31:0]       kept_period_next;
    logic [31:0]       kept_bytes_reg;
    logic [31:0]       kept_bytes_next;
    logic              have_measure_reg;
    logic              have_measure_next;
    logic              out_valid_reg;
    atm_pkg::result_t  result_reg;
    atm_pkg::result_t  result_new;
    logic [31:0]       prev_eff;
    logic [31:0]       diff;
    logic [32:0]       sum;
    logic [31:0]       sum_sat;
    logic              div_start;
    logic              div_done;
    logic [atm_pkg::DVD_W-1:0] quotient;
    logic              slot_free;
    logic              out_write;

    assign prev_eff = cmd.begin_region ? 32'd0 : prev_stamp_reg;
    assign diff     = cmd.stamp - prev_eff;
    assign sum      = {1'b0, held_bytes_reg} + {3'b000, cmd.acked};
    assign sum_sat  = sum[32] ? atm_pkg::SAT32 : sum[31:0];

    // state update for one event
    always_comb
    begin
        prev_stamp_next   = prev_stamp_reg;
        held_bytes_next   = held_bytes_reg;
        kept_period_next  = kept_period_reg;
        kept_bytes_next   = kept_bytes_reg;
        have_measure_next = 1'b0;
        if (cmd.is_ack)
        begin
            if (!cmd.qualified || (cmd.stamp == 32'd0) ||
                ((prev_eff != 32'd0) && (cmd.stamp < prev_eff)))
            begin
                kept_period_next = 32'd1;
                kept_bytes_next  = 32'd0;
                prev_stamp_next  = 32'd0;
            end
            else
            begin
                prev_stamp_next = cmd.stamp;
                if (prev_eff == 32'd0)
                begin
                    kept_period_next = 32'd1;
                    kept_bytes_next  = 32'd0;
                end
                else if (diff == 32'd0)
                begin
                    held_bytes_next = sum_sat;
                end
                else
                begin
                    have_measure_next = 1'b1;
                    kept_period_next  = diff;
                    kept_bytes_next   = sum_sat;
                    held_bytes_next   = 32'd0;
                end
            end
        end
    end

    assign slot_free = !out_valid_reg || pop;
    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign div_start = cmd_take && have_measure_next;
    assign out_write = (state_reg == S_DONE) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = have_measure_next ? S_DIV : S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_new = '0;
        if (have_measure_reg)
        begin
            result_new.measure_valid = 1'b1;
            result_new.period_ms     = kept_period_reg;
            result_new.byte_total    = kept_bytes_reg;
            result_new.rate_kbps     = (quotient[atm_pkg::DVD_W-1:31] != '0) ?
                                       atm_pkg::RATE_MAX : quotient[30:0];
        end
    end

    atm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({kept_bytes_next, 3'b000}),
        .divisor  (kept_period_next),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prev_stamp_reg   <= 32'd0;
            held_bytes_reg   <= 32'd0;
            kept_period_reg  <= 32'd1;
            kept_bytes_reg   <= 32'd0;
            have_measure_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_take)
            begin
                prev_stamp_reg   <= prev_stamp_next;
                held_bytes_reg   <= held_bytes_next;
                kept_period_reg  <= kept_period_next;
                kept_bytes_reg   <= kept_bytes_next;
                have_measure_reg <= have_measure_next;
            end
            if (out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_write)
        begin
            result_reg <= result_new;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/ack_timestamp_throughput_meter.sv =====
// throughput meter driven by send and ack events carrying peer timestamps
//
// input queue: drive item and raise push; a transfer happens on a clock
// edge with push high and full low. a two-entry queue holds classified
// events ahead of the execution side.
// result queue: while empty is low the oldest result sits on result; raise
// pop to take it. one result comes out for every event.
// event path: an event goes from the input queue through the execution
// state machine to the result register; when a measurement is valid it
// also passes through the 35-step one-bit-per-cycle divider that forms
// the kbps rate. the execution side takes no new event until it has
// written the result of the last; the divider is the limiting unit.
// reset: rst_n low clears the queues and the measurement state (no stamp
// held, no deferred bytes, period one, not valid).
// stall: a result waits in its output register until popped; the execution
// side stops once it holds its next result, and the input queue then fills
// and raises full.
module ack_timestamp_throughput_meter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  atm_pkg::in_item_t item,
    output logic              empty,
    input  logic              pop,
    output atm_pkg::result_t  result
);

    logic          cmd_valid;
    logic          cmd_take;
    atm_pkg::cmd_t cmd;

    atm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    atm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
